### rtl/sfa_pkg.sv
package sfa_pkg;

  // Default buffer depth and the fixed field widths.
  localparam int DEF_BUF_DEPTH = 64;
  localparam int TIMER_W       = 7;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;

  // Depths of the internal queues.
  localparam int MIDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRLF_ENABLE  = 1'b1;

  // Register values after reset.
  localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST = 7'd3;
  localparam logic               CRLF_ENABLE_RST  = 1'b1;

  // Line end characters.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } sfa_op_t;

  // Input word as it arrives.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [5:0] read_index;
  } sfa_in_t;

  // Result word.
  typedef struct packed {
    logic       frame_ready;
    logic [6:0] frame_length;
    logic       receiving;
    logic [7:0] read_data;
    logic       byte_dropped;
  } sfa_out_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    sfa_op_t    op;
    logic [7:0] data_byte;
    logic [5:0] read_index;
    logic       rd_ok;
  } sfa_cmd_t;

endpackage

### rtl/serial_frame_assembler_top.sv
// Channel   Ports                          Moves
// input     push, full, in_word            one command word
// result    empty, pop, out_word           one result word per command word
// config    cfg_we, cfg_index, cfg_wdata   one register write
//
// One word is taken every cycle while full is low; a result passes through the
// front register, the middle queue, the buffer read register and the result
// queue. The buffer is a single write and single read memory.
// rst_n is synchronous and clears all control state; buffer contents are not
// cleared. A full result queue stalls the back end, the middle queue absorbs
// it, and full rises only when the result queue, the result register, the
// middle queue and the front register are all full.
module serial_frame_assembler_top #(
  parameter int BUF_DEPTH = sfa_pkg::DEF_BUF_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  sfa_pkg::sfa_in_t              in_word,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output sfa_pkg::sfa_out_t             out_word,
  input  logic                          cfg_we,
  input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfa_pkg::CFG_W-1:0]     cfg_wdata
);
  import sfa_pkg::*;

  logic [TIMER_W-1:0] idle_r;
  logic               crlf_en_r;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  sfa_cmd_t           fe_word;
  sfa_cmd_t           q_word;
  logic               oq_push;
  logic               oq_full;
  sfa_out_t           oq_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r    <= IDLE_TIMEOUT_RST;
      crlf_en_r <= CRLF_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_r    <= cfg_wdata[TIMER_W-1:0];
        CFG_CRLF_ENABLE:  crlf_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify.
  sfa_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .full    (full),
    .q_push  (q_push),
    .q_word  (fe_word),
    .q_full  (q_full)
  );

  // Queue between front and back.
  sfa_fifo #(
    .DEPTH (MIDQ_DEPTH),
    .T     (sfa_cmd_t)
  ) u_midq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (fe_word),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_word),
    .empty   (q_empty)
  );

  // Back: frame buffer and state.
  sfa_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .idle_timeout (idle_r),
    .crlf_enable  (crlf_en_r),
    .oq_full      (oq_full),
    .oq_push      (oq_push),
    .oq_word      (oq_word)
  );

  // Result queue.
  sfa_fifo #(
    .DEPTH (OUTQ_DEPTH),
    .T     (sfa_out_t)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_word),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  // A waiting frame and an open frame never coexist.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_word.frame_ready && out_word.receiving))
    else $error("frame_ready and receiving both set");

  // The length reads zero unless a frame waits.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_word.frame_ready) |-> (out_word.frame_length == 7'd0))
    else $error("frame_length set with no frame pending");

  // A dropped byte never carries read data.
  a_drop_noread: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.byte_dropped) |-> (out_word.read_data == 8'd0))
    else $error("read_data set on a dropped byte");

  // Reset leaves the result side empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

### rtl/sfa_fifo.sv
module sfa_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/sfa_front.sv
module sfa_front #(
  parameter int BUF_DEPTH = sfa_pkg::DEF_BUF_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfa_pkg::sfa_in_t  in_word,
  output logic              full,
  output logic              q_push,
  output sfa_pkg::sfa_cmd_t q_word,
  input  logic              q_full
);
  import sfa_pkg::*;

  logic     fe_valid_r;
  logic     fe_valid_nxt;
  sfa_cmd_t fe_r;
  sfa_cmd_t fe_nxt;
  logic     accept;

  // The stage holds a word only while the queue behind it is full.
  assign full   = fe_valid_r && q_full;
  assign accept = push && !full;
  assign q_push = fe_valid_r;
  assign q_word = fe_r;

  // Decode the command and check the read index against the buffer.
  always_comb begin
    fe_nxt.op         = sfa_op_t'(in_word.command);
    fe_nxt.data_byte  = in_word.data_byte;
    fe_nxt.read_index = in_word.read_index;
    fe_nxt.rd_ok      = (in_word.command == OP_READ) &&
                        (32'(in_word.read_index) < 32'(BUF_DEPTH));
    fe_valid_nxt      = accept || (fe_valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_r <= fe_nxt;
    end
  end

endmodule

### rtl/sfa_back.sv
module sfa_back #(
  parameter int BUF_DEPTH = sfa_pkg::DEF_BUF_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sfa_pkg::sfa_cmd_t             q_word,
  output logic                          q_pop,
  input  logic [sfa_pkg::TIMER_W-1:0]   idle_timeout,
  input  logic                          crlf_enable,
  input  logic                          oq_full,
  output logic                          oq_push,
  output sfa_pkg::sfa_out_t             oq_word
);
  import sfa_pkg::*;

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int WPW = $clog2(BUF_DEPTH + 1);

  // Frame buffer.
  logic [7:0]         mem [BUF_DEPTH];
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data_r;

  // Frame state.
  logic [WPW-1:0]     wpos_r, wpos_nxt;
  logic [WPW-1:0]     held_r, held_nxt;
  logic               pending_r, pending_nxt;
  logic               collecting_r, collecting_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [7:0]         prev_r, prev_nxt;

  // Result stage, waiting for the registered buffer read.
  logic               res_valid_r, res_valid_nxt;
  sfa_out_t           res_r, res_nxt;
  logic               rd_ok_r;

  logic               exec;
  logic [WPW-1:0]     wpos_inc;
  logic               crlf_seen;
  logic               dropped;

  // One word runs each cycle unless the result stage is blocked.
  assign exec     = !q_empty && (!res_valid_r || !oq_full);
  assign q_pop    = exec;
  assign wr_addr  = AW'(wpos_r);
  assign rd_addr  = AW'(q_word.read_index);
  assign wpos_inc = wpos_r + 1'b1;
  assign crlf_seen = (wpos_r != '0) && (prev_r == CHAR_CR) &&
                     (q_word.data_byte == CHAR_LF);

  // Frame state update for the word at the head of the queue.
  always_comb begin
    wpos_nxt       = wpos_r;
    held_nxt       = held_r;
    pending_nxt    = pending_r;
    collecting_nxt = collecting_r;
    timer_nxt      = timer_r;
    prev_nxt       = prev_r;
    mem_we         = 1'b0;
    dropped        = 1'b0;
    if (exec) begin
      unique case (q_word.op)
        OP_BYTE: begin
          if (pending_r) begin
            // A byte while a frame waits is lost but restarts the timer.
            collecting_nxt = 1'b0;
            timer_nxt      = idle_timeout;
            dropped        = 1'b1;
          end else if (wpos_r != '0 && timer_r == '0) begin
            // Silence ran out: close what is held, drop this byte.
            pending_nxt    = 1'b1;
            collecting_nxt = 1'b0;
            held_nxt       = wpos_r;
            wpos_nxt       = '0;
            dropped        = 1'b1;
          end else begin
            mem_we         = 1'b1;
            collecting_nxt = 1'b1;
            timer_nxt      = idle_timeout;
            prev_nxt       = q_word.data_byte;
            wpos_nxt       = wpos_inc;
            if (crlf_enable && crlf_seen) begin
              pending_nxt    = 1'b1;
              collecting_nxt = 1'b0;
              held_nxt       = wpos_inc;
              wpos_nxt       = '0;
            end else if (wpos_inc == WPW'(BUF_DEPTH)) begin
              pending_nxt    = 1'b1;
              collecting_nxt = 1'b0;
              held_nxt       = WPW'(BUF_DEPTH);
              wpos_nxt       = '0;
            end
          end
        end
        OP_TICK: begin
          if (timer_r != '0) begin
            timer_nxt = timer_r - 1'b1;
          end
        end
        OP_READ: begin
        end
        OP_RELEASE: begin
          pending_nxt = 1'b0;
          held_nxt    = '0;
        end
        default: begin
        end
      endcase
    end

    res_nxt.frame_ready  = pending_nxt;
    res_nxt.frame_length = 7'(held_nxt);
    res_nxt.receiving    = collecting_nxt;
    res_nxt.read_data    = '0;
    res_nxt.byte_dropped = dropped;
    res_valid_nxt        = exec || (res_valid_r && oq_full);
  end

  // Buffer write and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_word.data_byte;
    end
    if (exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r       <= '0;
      held_r       <= '0;
      pending_r    <= 1'b0;
      collecting_r <= 1'b0;
      timer_r      <= '0;
      prev_r       <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      wpos_r       <= wpos_nxt;
      held_r       <= held_nxt;
      pending_r    <= pending_nxt;
      collecting_r <= collecting_nxt;
      timer_r      <= timer_nxt;
      prev_r       <= prev_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (exec) begin
      res_r   <= res_nxt;
      rd_ok_r <= q_word.rd_ok;
    end
  end

  // Merge the read data into the result word.
  always_comb begin
    oq_word           = res_r;
    oq_word.read_data = rd_ok_r ? rd_data_r : 8'd0;
  end
  assign oq_push = res_valid_r;

endmodule
